>>> rtl/core/kmp_pkg.sv
package kmp_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_TEXT    = 65536;

    localparam int BYTE_W  = 8;
    localparam int PAT_W   = BYTE_W * MAX_PATTERN;
    localparam int LEN_W   = 4;
    localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W   = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(1);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_BUILD,
        ST_BUILD_FALL,
        ST_IDLE,
        ST_SEARCH,
        ST_SEARCH_FALL
    } state_t;

    // Clamp the programmed length into 1..MAX_PATTERN.
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = len;
        if (n == LEN_W'(0))
            n = LEN_W'(1);
        if (n > LEN_W'(MAX_PATTERN))
            n = LEN_W'(MAX_PATTERN);
        return n;
    endfunction

endpackage

>>> rtl/core/kmp_substring_search_core.sv
// Channel   | Handshake                  | Payload
// text      | text_valid / text_stall    | text_byte, text_last
// result    | result_valid / result_stall| match_found, match_start, position_overflow
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A text byte that matches directly passes through the compare state once; each
// fallback step, one read of the failure-table memory, adds a pass through the
// fallback state and back. After reset and after every config write the table is
// rebuilt (one compare or memory read per cycle); text is stalled meanwhile.
// A stalled result holds the finished byte; the next byte is still accepted
// and waits in the compare state until the result register frees up.
module kmp_substring_search_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   text_valid,
    output logic                                   text_stall,
    input  logic [kmp_pkg::BYTE_W-1:0]             text_byte,
    input  logic                                   text_last,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic                                   match_found,
    output logic [kmp_pkg::POS_W-1:0]              match_start,
    output logic                                   position_overflow,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [kmp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [kmp_pkg::PAT_W-1:0]              cfg_data
);

    localparam int BYTE_W = kmp_pkg::BYTE_W;
    localparam int LEN_W  = kmp_pkg::LEN_W;
    localparam int IDX_W  = kmp_pkg::IDX_W;
    localparam int POS_W  = kmp_pkg::POS_W;

    kmp_pkg::state_t state_reg, state_next;

    logic [kmp_pkg::PAT_W-1:0] pattern_reg, pattern_next;
    logic [LEN_W-1:0]          length_reg, length_next;

    logic [LEN_W-1:0] matched_reg, matched_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             found_reg, found_next;
    logic [POS_W-1:0] offset_reg, offset_next;
    logic             ovf_reg, ovf_next;

    logic [BYTE_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  k_reg, k_next;

    logic             rv_reg, rv_next;
    logic             rfound_reg, rfound_next;
    logic [POS_W-1:0] rstart_reg, rstart_next;
    logic             rovf_reg, rovf_next;

    // failure table memory
    logic [LEN_W-1:0] ft_mem [kmp_pkg::MAX_PATTERN];
    logic [LEN_W-1:0] ft_rdata_reg;
    logic             ft_we;
    logic [IDX_W-1:0] ft_waddr;
    logic [LEN_W-1:0] ft_wdata;
    logic [IDX_W-1:0] ft_raddr;

    logic [LEN_W-1:0]  n_len;
    logic [IDX_W-1:0]  j_idx;
    logic [BYTE_W-1:0] pat_j, pat_i, pat_k;
    logic              hit, busy_done, search_fall, build_fall, build_hit;
    logic [LEN_W-1:0]  j_adv;
    logic [IDX_W-1:0]  k_adv;
    logic              new_found;
    logic              text_accept, cfg_accept, out_free;

    assign n_len       = kmp_pkg::eff_length(length_reg);
    assign j_idx       = j_reg[IDX_W-1:0];
    assign pat_j       = pattern_reg[j_idx * BYTE_W +: BYTE_W];
    assign pat_i       = pattern_reg[i_reg * BYTE_W +: BYTE_W];
    assign pat_k       = pattern_reg[k_reg * BYTE_W +: BYTE_W];
    assign hit         = (char_reg == pat_j);
    assign busy_done   = found_reg || ovf_reg;
    assign search_fall = !busy_done && (j_reg != LEN_W'(0)) && !hit;
    assign build_hit   = (pat_i == pat_k);
    assign build_fall  = (k_reg != IDX_W'(0)) && !build_hit;
    assign j_adv       = j_reg + LEN_W'(hit);
    assign k_adv       = k_reg + IDX_W'(build_hit);
    assign new_found   = !busy_done && (j_adv >= n_len);
    assign out_free    = !rv_reg || !result_stall;

    assign cfg_ready   = (state_reg == kmp_pkg::ST_IDLE);
    assign text_stall  = (state_reg != kmp_pkg::ST_IDLE) || cfg_valid;
    assign cfg_accept  = cfg_valid && cfg_ready;
    assign text_accept = text_valid && !text_stall;

    assign result_valid      = rv_reg;
    assign match_found       = rfound_reg;
    assign match_start       = rstart_reg;
    assign position_overflow = rovf_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmp_pkg::ST_INIT:
            begin
                if (n_len > LEN_W'(2))
                    state_next = kmp_pkg::ST_BUILD;
                else
                    state_next = kmp_pkg::ST_IDLE;
            end
            kmp_pkg::ST_BUILD:
            begin
                if (build_fall)
                    state_next = kmp_pkg::ST_BUILD_FALL;
                else if ((LEN_W'(i_reg) + LEN_W'(2)) >= n_len)
                    state_next = kmp_pkg::ST_IDLE;
            end
            kmp_pkg::ST_BUILD_FALL:
                state_next = kmp_pkg::ST_BUILD;
            kmp_pkg::ST_IDLE:
            begin
                if (cfg_accept)
                    state_next = kmp_pkg::ST_INIT;
                else if (text_accept)
                    state_next = kmp_pkg::ST_SEARCH;
            end
            kmp_pkg::ST_SEARCH:
            begin
                if (search_fall)
                    state_next = kmp_pkg::ST_SEARCH_FALL;
                else if (out_free)
                    state_next = kmp_pkg::ST_IDLE;
            end
            kmp_pkg::ST_SEARCH_FALL:
                state_next = kmp_pkg::ST_SEARCH;
            default:
                state_next = kmp_pkg::ST_INIT;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        matched_next = matched_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        offset_next  = offset_reg;
        ovf_next     = ovf_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        rv_next      = rv_reg && result_stall;
        rfound_next  = rfound_reg;
        rstart_next  = rstart_reg;
        rovf_next    = rovf_reg;
        ft_we        = 1'b0;
        ft_waddr     = IDX_W'(1);
        ft_wdata     = LEN_W'(0);
        ft_raddr     = j_idx;

        unique case (state_reg)
            kmp_pkg::ST_INIT:
            begin
                // entry 1 is always zero; entries from 2 up come from the build loop
                ft_we    = 1'b1;
                ft_waddr = IDX_W'(1);
                ft_wdata = LEN_W'(0);
                i_next   = IDX_W'(1);
                k_next   = IDX_W'(0);
            end
            kmp_pkg::ST_BUILD:
            begin
                ft_raddr = k_reg;
                if (!build_fall)
                begin
                    ft_we    = 1'b1;
                    ft_waddr = i_reg + IDX_W'(1);
                    ft_wdata = LEN_W'(k_adv);
                    k_next   = k_adv;
                    i_next   = i_reg + IDX_W'(1);
                end
            end
            kmp_pkg::ST_BUILD_FALL:
                k_next = ft_rdata_reg[IDX_W-1:0];
            kmp_pkg::ST_IDLE:
            begin
                if (cfg_accept)
                begin
                    if (cfg_index == kmp_pkg::CFG_PATTERN_BYTES)
                        pattern_next = cfg_data;
                    else if (cfg_index == kmp_pkg::CFG_PATTERN_LENGTH)
                        length_next = cfg_data[LEN_W-1:0];
                    if (cfg_index == kmp_pkg::CFG_PATTERN_BYTES ||
                        cfg_index == kmp_pkg::CFG_PATTERN_LENGTH)
                    begin
                        matched_next = LEN_W'(0);
                        pos_next     = POS_W'(0);
                        found_next   = 1'b0;
                        offset_next  = POS_W'(0);
                        ovf_next     = 1'b0;
                    end
                end
                else if (text_accept)
                begin
                    char_next = text_byte;
                    last_next = text_last;
                    j_next    = (matched_reg >= n_len) ? LEN_W'(0) : matched_reg;
                end
            end
            kmp_pkg::ST_SEARCH:
            begin
                ft_raddr = j_idx;
                if (!search_fall && out_free)
                begin
                    if (!busy_done)
                    begin
                        if (new_found)
                        begin
                            found_next   = 1'b1;
                            offset_next  = pos_reg + POS_W'(1) - POS_W'(n_len);
                            matched_next = LEN_W'(0);
                        end
                        else
                            matched_next = j_adv;
                        if (pos_reg == kmp_pkg::POS_LAST)
                            ovf_next = !new_found;
                        else
                            pos_next = pos_reg + POS_W'(1);
                    end
                    rv_next     = 1'b1;
                    rfound_next = found_next;
                    rstart_next = found_next ? offset_next : POS_W'(0);
                    rovf_next   = ovf_next;
                    // last byte of the text: report, then restart the search
                    if (last_reg)
                    begin
                        matched_next = LEN_W'(0);
                        pos_next     = POS_W'(0);
                        found_next   = 1'b0;
                        offset_next  = POS_W'(0);
                        ovf_next     = 1'b0;
                    end
                end
            end
            kmp_pkg::ST_SEARCH_FALL:
                j_next = ft_rdata_reg;
            default:
            begin
                ft_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ft_we)
            ft_mem[ft_waddr] <= ft_wdata;
        ft_rdata_reg <= ft_mem[ft_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kmp_pkg::ST_INIT;
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
            matched_reg <= '0;
            pos_reg     <= '0;
            found_reg   <= 1'b0;
            offset_reg  <= '0;
            ovf_reg     <= 1'b0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            matched_reg <= matched_next;
            pos_reg     <= pos_next;
            found_reg   <= found_next;
            offset_reg  <= offset_next;
            ovf_reg     <= ovf_next;
            rv_reg      <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        last_reg   <= last_next;
        j_reg      <= j_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        rfound_reg <= rfound_next;
        rstart_reg <= rstart_next;
        rovf_reg   <= rovf_next;
    end

endmodule

>>> rtl/core/kmp_checker.sv
module kmp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          text_valid,
    input logic                          text_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic                          match_found,
    input logic [kmp_pkg::POS_W-1:0]     match_start,
    input logic                          position_overflow,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(match_start)
            && $stable(match_found) && $stable(position_overflow))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !match_found |-> match_start == '0)
        else $error("start offset without a match");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && match_found |-> !position_overflow)
        else $error("match and overflow reported together");

    // one byte is in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_stall |=> text_stall)
        else $error("text accepted in consecutive cycles");

    // the table rebuild blocks text
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> text_stall && !cfg_ready)
        else $error("text or config taken during table rebuild");

endmodule

bind kmp_substring_search_core kmp_checker u_kmp_checker (.*);

>>> bench/kmp_substring_search_core_tb.sv
module kmp_substring_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PATTERN = kmp_pkg::MAX_PATTERN;
    localparam int MAX_TEXT    = kmp_pkg::MAX_TEXT;
    localparam int BYTE_W      = kmp_pkg::BYTE_W;
    localparam int PAT_W       = kmp_pkg::PAT_W;
    localparam int LEN_W       = kmp_pkg::LEN_W;
    localparam int POS_W       = kmp_pkg::POS_W;
    localparam int CFG_IDX_W   = kmp_pkg::CFG_IDX_W;

    localparam int RANDOM_BYTES = 1600;
    localparam int DRAIN_CYCLES = 40;
    localparam longint LIMIT_NS = 30_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = kmp_pkg::CFG_PATTERN_LENGTH + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = '1;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
        logic             ovf;
    } match_report_t;

    typedef enum logic {ROW_TEXT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [PAT_W-1:0]     data;
        logic [BYTE_W-1:0]    tbyte;
        logic                 last;
        logic                 pinned;
        match_report_t        want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 text_valid;
    logic                 text_stall;
    logic [BYTE_W-1:0]    text_byte;
    logic                 text_last;
    logic                 result_valid;
    logic                 result_stall;
    logic                 match_found;
    logic [POS_W-1:0]     match_start;
    logic                 position_overflow;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PAT_W-1:0]     cfg_data;

    // search model state
    logic [PAT_W-1:0] pat_bytes;
    logic [LEN_W-1:0] pat_len;
    logic [LEN_W-1:0] fail_tbl [MAX_PATTERN];
    int               srch_matched;
    int               srch_pos;
    logic             srch_found;
    logic [POS_W-1:0] srch_offset;
    logic             srch_ovf;

    match_report_t predicted_reports [$];
    stim_row_t     directed_rows [$];

    int idle_mode;
    int fails;
    int text_bytes_sent;
    int texts_sent;
    int reg_writes;
    int found_reports;
    int overflow_reports;

    kmp_substring_search_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .text_valid        (text_valid),
        .text_stall        (text_stall),
        .text_byte         (text_byte),
        .text_last         (text_last),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .match_found       (match_found),
        .match_start       (match_start),
        .position_overflow (position_overflow),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int active_len();
        int n;
        n = int'(pat_len);
        if (n < 1)
            n = 1;
        if (n > MAX_PATTERN)
            n = MAX_PATTERN;
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] pat_at(input int i);
        return pat_bytes[(i % MAX_PATTERN) * BYTE_W +: BYTE_W];
    endfunction

    function automatic void clear_search();
        srch_matched = 0;
        srch_pos     = 0;
        srch_found   = 1'b0;
        srch_offset  = '0;
        srch_ovf     = 1'b0;
    endfunction

    // fail_tbl[j]: longest proper border of the first j pattern bytes
    function automatic void rebuild_failure_table();
        int n;
        int k;
        n = active_len();
        k = 0;
        for (int i = 0; i < MAX_PATTERN; i++)
            fail_tbl[i] = '0;
        for (int i = 1; i + 1 < n; i++)
        begin
            while (k > 0 && pat_at(i) != pat_at(k))
                k = int'(fail_tbl[k]);
            if (pat_at(i) == pat_at(k))
                k++;
            fail_tbl[i + 1] = LEN_W'(k);
        end
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [PAT_W-1:0] data);
        if (idx == kmp_pkg::CFG_PATTERN_BYTES)
            pat_bytes = data;
        else if (idx == kmp_pkg::CFG_PATTERN_LENGTH)
            pat_len = data[LEN_W-1:0];
        else
            return;
        rebuild_failure_table();
        clear_search();
    endfunction

    function automatic match_report_t kmp_step(input logic [BYTE_W-1:0] c, input logic last);
        match_report_t rep;
        int n;
        int j;
        if (!srch_found && !srch_ovf)
        begin
            n = active_len();
            j = srch_matched;
            if (j >= n)
                j = 0;
            while (j > 0 && c != pat_at(j))
                j = int'(fail_tbl[j % MAX_PATTERN]);
            if (c == pat_at(j))
                j++;
            if (j >= n)
            begin
                srch_found   = 1'b1;
                srch_offset  = POS_W'(srch_pos + 1 - n);
                srch_matched = 0;
            end
            else
                srch_matched = j;
            // saturate at the last offset; a miss there marks overflow
            if (srch_pos >= MAX_TEXT - 1)
            begin
                if (!srch_found)
                    srch_ovf = 1'b1;
            end
            else
                srch_pos++;
        end
        rep.found = srch_found;
        rep.start = srch_found ? srch_offset : '0;
        rep.ovf   = srch_ovf;
        if (last)
            clear_search();
        return rep;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0 || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
        stim_row_t row;
        row = '{ROW_REG, idx, data, '0, 1'b0, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void text_row(input logic [BYTE_W-1:0] b, input logic last);
        stim_row_t row;
        row = '{ROW_TEXT, '0, '0, b, last, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void known_row(input logic [BYTE_W-1:0] b, input logic last,
                                      input logic found, input logic [POS_W-1:0] start,
                                      input logic ovf);
        stim_row_t row;
        row = '{ROW_TEXT, '0, '0, b, last, 1'b1, '{found, start, ovf}};
        directed_rows.push_back(row);
    endfunction

    // Leaves cfg_valid high; the next text transaction drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
        text_valid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg_write(idx, data);
        reg_writes++;
    endtask

    // Leaves text_valid high so back-to-back bytes need no bubble.
    task automatic send_text(input logic [BYTE_W-1:0] b, input logic last,
                             input logic pinned, input match_report_t pinned_rep);
        int gap;
        match_report_t rep;
        gap = pick_gap();
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        text_last  <= last;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        rep = kmp_step(b, last);
        predicted_reports.push_back(pinned ? pinned_rep : rep);
        text_bytes_sent++;
        if (last)
            texts_sent++;
    endtask

    initial
    begin
        int hold;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        match_report_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (match_found)
                found_reports++;
            if (position_overflow)
                overflow_reports++;
            if (predicted_reports.size() == 0)
            begin
                $error("result transaction with no text byte pending");
                fails++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                if (match_found !== want.found)
                begin
                    $error("match_found: expected %0d, got %0d", want.found, match_found);
                    fails++;
                end
                if (match_start !== want.start)
                begin
                    $error("match_start: expected %0d, got %0d", want.start, match_start);
                    fails++;
                end
                if (position_overflow !== want.ovf)
                begin
                    $error("position_overflow: expected %0d, got %0d",
                           want.ovf, position_overflow);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        int phase;
        int phase_goal;
        int phase_bytes;
        int random_bytes;
        int n_text;
        int plen;
        int pos;
        int r;
        logic [LEN_W-1:0]  len_pick;
        logic [PAT_W-1:0]  pat;
        logic [PAT_W-1:0]  len_word;
        logic [BYTE_W-1:0] alpha [3];
        logic [BYTE_W-1:0] text_buf [$];

        rst_n      = 1'b0;
        text_valid = 1'b0;
        text_byte  = '0;
        text_last  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_mode  = 0;
        fails      = 0;
        text_bytes_sent  = 0;
        texts_sent       = 0;
        reg_writes       = 0;
        found_reports    = 0;
        overflow_reports = 0;

        pat_bytes = '0;
        pat_len   = LEN_W'(1);
        clear_search();
        rebuild_failure_table();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern is a single zero byte
        known_row(8'h01, 1'b0, 1'b0, 16'd0, 1'b0);
        known_row(8'h00, 1'b1, 1'b1, 16'd1, 1'b0);
        reg_row(kmp_pkg::CFG_PATTERN_LENGTH, '0);
        known_row(8'h00, 1'b1, 1'b1, 16'd0, 1'b0);
        // "aab": the third byte forces a fallback
        reg_row(kmp_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0062_6161);
        reg_row(kmp_pkg::CFG_PATTERN_LENGTH, 64'd3);
        text_row(8'h61, 1'b0);
        text_row(8'h61, 1'b0);
        text_row(8'h61, 1'b0);
        text_row(8'h62, 1'b1);
        reg_row(CFG_LAST_INDEX, '1);
        text_row(8'h61, 1'b0);
        text_row(8'h61, 1'b0);
        text_row(8'h62, 1'b1);
        // oversized length clamps to a full eight-byte pattern
        reg_row(kmp_pkg::CFG_PATTERN_BYTES, '1);
        reg_row(kmp_pkg::CFG_PATTERN_LENGTH, 64'd15);
        for (int i = 0; i < MAX_PATTERN; i++)
            text_row(8'hFF, 1'b0);
        known_row(8'h00, 1'b1, 1'b1, 16'd0, 1'b0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            else
                send_text(directed_rows[i].tbyte, directed_rows[i].last,
                          directed_rows[i].pinned, directed_rows[i].want);
        end

        phase = 0;
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            idle_mode = (phase % 4 == 0) ? 0 : 1;
            for (int k = 0; k < 3; k++)
                alpha[k] = BYTE_W'($urandom_range(0, 255));
            for (int k = 0; k < MAX_PATTERN; k++)
                pat[k * BYTE_W +: BYTE_W] = ($urandom_range(0, 99) < 85) ?
                                            alpha[$urandom_range(0, 2)] : BYTE_W'($urandom);
            if (phase < 4)
                len_pick = (phase == 0) ? LEN_W'(1) : (phase == 1) ? LEN_W'(MAX_PATTERN) :
                           (phase == 2) ? LEN_W'(0) : LEN_W'(15);
            else if ($urandom_range(0, 9) < 8)
                len_pick = LEN_W'($urandom_range(1, MAX_PATTERN));
            else
                len_pick = LEN_W'($urandom_range(0, 15));
            len_word = {$urandom, $urandom};
            len_word[LEN_W-1:0] = len_pick;

            r = $urandom_range(0, 9);
            if (phase < 4 || r < 6)
            begin
                if ($urandom_range(0, 1))
                begin
                    write_reg(kmp_pkg::CFG_PATTERN_BYTES, pat);
                    write_reg(kmp_pkg::CFG_PATTERN_LENGTH, len_word);
                end
                else
                begin
                    write_reg(kmp_pkg::CFG_PATTERN_LENGTH, len_word);
                    write_reg(kmp_pkg::CFG_PATTERN_BYTES, pat);
                end
            end
            else if (r < 8)
                write_reg(kmp_pkg::CFG_PATTERN_LENGTH, len_word);
            else
                write_reg(kmp_pkg::CFG_PATTERN_BYTES, pat);
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                          {$urandom, $urandom});

            phase_goal  = $urandom_range(120, 260);
            phase_bytes = 0;
            while (phase_bytes < phase_goal)
            begin
                r = $urandom_range(0, 99);
                n_text = (r < 10) ? 1 : (r < 85) ? $urandom_range(2, 24) :
                                                   $urandom_range(25, 80);
                text_buf.delete();
                for (int k = 0; k < n_text; k++)
                    text_buf.push_back(($urandom_range(0, 99) < 80) ?
                                       alpha[$urandom_range(0, 2)] : BYTE_W'($urandom));
                // plant the pattern, now and then with one byte spoiled
                plen = active_len();
                if (n_text >= plen && $urandom_range(0, 1))
                begin
                    pos = $urandom_range(0, n_text - plen);
                    for (int k = 0; k < plen; k++)
                        text_buf[pos + k] = pat_at(k);
                    if ($urandom_range(0, 3) == 0)
                        text_buf[pos + $urandom_range(0, plen - 1)] ^=
                            BYTE_W'($urandom_range(1, 255));
                end
                for (int k = 0; k < n_text; k++)
                    send_text(text_buf[k], k == n_text - 1, 1'b0, '0);
                phase_bytes  += n_text;
                random_bytes += n_text;
            end
            phase++;
        end
        text_valid <= 1'b0;

        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Searched %0d text bytes in %0d texts across %0d register writes,",
                 text_bytes_sent, texts_sent, reg_writes);
        $display("  %0d reports showed a match and %0d an exhausted offset range.",
                 found_reports, overflow_reports);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
